// ===== src/adc_plc_pkg.sv =====
// Shared types, constants and register codes for the ADC piecewise-linear calibration core.
`default_nettype none

package adc_plc_pkg;

  // Converter and scaling
  localparam int ADC_BITS     = 12;
  localparam int MV_W         = 15;                     // raw and breakpoint width
  localparam int CORR_W       = 16;                     // corrected result width
  localparam int FULL_SCALE   = 16500;                  // millivolts at full code
  localparam int SCALE_W      = 15;                     // bits of FULL_SCALE
  localparam int PROD_W       = ADC_BITS + SCALE_W;     // adc * FULL_SCALE
  localparam longint unsigned ADC_MAX = (64'd1 << ADC_BITS) - 64'd1;

  // Exact division by ADC_MAX: ceiling reciprocal with a shift wide enough
  // that no correction step is needed for any PROD_W-bit dividend.
  localparam int RECIP_SHIFT  = PROD_W + ADC_BITS;
  localparam int RECIP_W      = PROD_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + ADC_MAX - 64'd1) / ADC_MAX;
  localparam int SCALED_W     = PROD_W + RECIP_W;

  // Interpolation datapath
  localparam int NUM_POINTS   = 4;
  localparam int DIFF_W       = MV_W + 1;               // signed differences
  localparam int MAG_W        = 2 * DIFF_W;             // |dx_in * dy| and quotient
  localparam int QS_W         = MAG_W + 1;              // signed quotient
  localparam int SUM_W        = QS_W + 1;               // y0 + quotient
  localparam int DIV_STEPS    = MAG_W;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = MV_W;

  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_3 = 3'd7;

  localparam logic [MV_W-1:0] IN_POINT_RESET  [NUM_POINTS] =
    '{15'd960, 15'd1700, 15'd2060, 15'd3080};
  localparam logic [MV_W-1:0] OUT_POINT_RESET [NUM_POINTS] =
    '{15'd1720, 15'd2520, 15'd2890, 15'd3930};

  // Segment codes
  localparam logic [1:0] SEG_0 = 2'd0;
  localparam logic [1:0] SEG_1 = 2'd1;
  localparam logic [1:0] SEG_2 = 2'd2;

  // Pipeline stage positions
  localparam int ST_SCALE   = 0;
  localparam int ST_RAW     = 1;
  localparam int ST_SEG     = 2;
  localparam int ST_OPER    = 3;
  localparam int ST_MUL     = 4;
  localparam int ST_ABS     = 5;
  localparam int ST_DIV0    = 6;
  localparam int ST_SIGN    = ST_DIV0 + DIV_STEPS;
  localparam int ST_OUT     = ST_SIGN + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

  // Everything one request carries down the pipeline
  typedef struct packed {
    logic [PROD_W-1:0]        prod_scale;
    logic [MV_W-1:0]          raw;
    logic [1:0]               seg;
    logic                     seg_ok;
    logic [MV_W-1:0]          y0;
    logic signed [DIFF_W-1:0] nx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dx;
    logic                     bypass;
    logic signed [MAG_W-1:0]  prod;
    logic                     neg;
    logic [MV_W-1:0]          den;
    logic [MV_W-1:0]          rem;
    logic [MAG_W-1:0]         nq;
    logic signed [QS_W-1:0]   qs;
    logic signed [CORR_W-1:0] corr;
    logic                     flag;
  } pipe_t;

endpackage

`default_nettype wire

// ===== src/adc_piecewise_linear_calibration_core.sv =====
// Top level of the ADC piecewise-linear calibration core: scaling, segment pick, divider.
`default_nettype none

// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+-------------------------------------
// sample    | in        | sample_valid / sample_stall  | adc_sample
// result    | out       | result_valid / result_stall  | raw_millivolts, corrected_millivolts,
//           |           |                              | out_flag
// cfg       | in        | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One request enters per cycle while sample_stall is low; each result leaves after all
// NUM_STAGES stages, a count set by the one-bit-per-stage restoring divider (32 stages) plus
// eight stages of scaling, segment selection, multiply, sign fix-up and saturation.
// Reset clears all stage valid bits and loads the breakpoint registers with defaults.
// A stall on the result side holds only the stages that are full back to the first
// empty stage, so bubbles close up and the core keeps taking requests until every stage is full.
// cfg_ready is always high; writes take effect on the next cycle.

module adc_piecewise_linear_calibration_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // sample channel
  input  wire logic                                    sample_valid,
  output logic                                         sample_stall,
  input  wire logic [adc_plc_pkg::ADC_BITS-1:0]        adc_sample,
  // result channel
  output logic                                         result_valid,
  input  wire logic                                    result_stall,
  output logic [adc_plc_pkg::MV_W-1:0]                 raw_millivolts,
  output logic signed [adc_plc_pkg::CORR_W-1:0]        corrected_millivolts,
  output logic                                         out_flag,
  // configuration channel
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [adc_plc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [adc_plc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int N = adc_plc_pkg::NUM_STAGES;

  // ------------------------------------------------------------------
  // Breakpoint registers
  // ------------------------------------------------------------------
  logic [adc_plc_pkg::MV_W-1:0] in_pt  [adc_plc_pkg::NUM_POINTS];
  logic [adc_plc_pkg::MV_W-1:0] out_pt [adc_plc_pkg::NUM_POINTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pt  <= adc_plc_pkg::IN_POINT_RESET;
      out_pt <= adc_plc_pkg::OUT_POINT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        adc_plc_pkg::REG_IN_POINT_0:  in_pt[0]  <= cfg_data;
        adc_plc_pkg::REG_IN_POINT_1:  in_pt[1]  <= cfg_data;
        adc_plc_pkg::REG_IN_POINT_2:  in_pt[2]  <= cfg_data;
        adc_plc_pkg::REG_IN_POINT_3:  in_pt[3]  <= cfg_data;
        adc_plc_pkg::REG_OUT_POINT_0: out_pt[0] <= cfg_data;
        adc_plc_pkg::REG_OUT_POINT_1: out_pt[1] <= cfg_data;
        adc_plc_pkg::REG_OUT_POINT_2: out_pt[2] <= cfg_data;
        adc_plc_pkg::REG_OUT_POINT_3: out_pt[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Pipeline: valid bits, stage payloads, per-stage advance
  // ------------------------------------------------------------------
  logic                     vld [N];
  adc_plc_pkg::pipe_t       stg [N];
  adc_plc_pkg::pipe_t       stg_next [N];
  logic [N-1:0]             adv;

  // A stage may load when it is empty or when its contents move on.
  always_comb begin
    adv[N-1] = !vld[N-1] || !result_stall;
    for (int k = N - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign sample_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        vld[0] <= sample_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (adv[k]) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage logic
  // ------------------------------------------------------------------
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_stage
      if (g == adc_plc_pkg::ST_SCALE) begin : g_scale
        // adc * full-scale millivolts
        always_comb begin
          stg_next[g] = '0;
          stg_next[g].prod_scale = adc_plc_pkg::PROD_W'(adc_sample) *
                                   adc_plc_pkg::PROD_W'(adc_plc_pkg::FULL_SCALE);
        end
      end else if (g == adc_plc_pkg::ST_RAW) begin : g_raw
        // Divide by the full code through the ceiling reciprocal; exact, no fix-up.
        logic [adc_plc_pkg::SCALED_W-1:0] scaled;
        always_comb begin
          scaled = adc_plc_pkg::SCALED_W'(stg[g-1].prod_scale) *
                   adc_plc_pkg::SCALED_W'(adc_plc_pkg::RECIP);
          stg_next[g] = stg[g-1];
          stg_next[g].raw = scaled[adc_plc_pkg::RECIP_SHIFT +: adc_plc_pkg::MV_W];
        end
      end else if (g == adc_plc_pkg::ST_SEG) begin : g_seg
        // Extrapolate below the first and above the last breakpoint,
        // otherwise take the first segment whose ends hold raw; if none does, clear seg_ok.
        logic [adc_plc_pkg::MV_W-1:0] x;
        always_comb begin
          x = stg[g-1].raw;
          stg_next[g] = stg[g-1];
          stg_next[g].seg_ok = 1'b1;
          if (x <= in_pt[0]) begin
            stg_next[g].seg = adc_plc_pkg::SEG_0;
          end else if (x >= in_pt[3]) begin
            stg_next[g].seg = adc_plc_pkg::SEG_2;
          end else if (x >= in_pt[0] && x <= in_pt[1]) begin
            stg_next[g].seg = adc_plc_pkg::SEG_0;
          end else if (x >= in_pt[1] && x <= in_pt[2]) begin
            stg_next[g].seg = adc_plc_pkg::SEG_1;
          end else if (x >= in_pt[2] && x <= in_pt[3]) begin
            stg_next[g].seg = adc_plc_pkg::SEG_2;
          end else begin
            stg_next[g].seg    = adc_plc_pkg::SEG_0;
            stg_next[g].seg_ok = 1'b0;
          end
        end
      end else if (g == adc_plc_pkg::ST_OPER) begin : g_oper
        logic [adc_plc_pkg::MV_W-1:0] x0, x1, y0, y1;
        always_comb begin
          case (stg[g-1].seg)
            adc_plc_pkg::SEG_0: begin
              x0 = in_pt[0]; x1 = in_pt[1]; y0 = out_pt[0]; y1 = out_pt[1];
            end
            adc_plc_pkg::SEG_1: begin
              x0 = in_pt[1]; x1 = in_pt[2]; y0 = out_pt[1]; y1 = out_pt[2];
            end
            default: begin
              x0 = in_pt[2]; x1 = in_pt[3]; y0 = out_pt[2]; y1 = out_pt[3];
            end
          endcase
          stg_next[g] = stg[g-1];
          stg_next[g].y0 = y0;
          stg_next[g].nx = $signed({1'b0, stg[g-1].raw}) - $signed({1'b0, x0});
          stg_next[g].dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
          stg_next[g].dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
          stg_next[g].bypass = !stg[g-1].seg_ok || (x1 == x0);
        end
      end else if (g == adc_plc_pkg::ST_MUL) begin : g_mul
        always_comb begin
          stg_next[g] = stg[g-1];
          stg_next[g].prod = adc_plc_pkg::MAG_W'(stg[g-1].nx) *
                             adc_plc_pkg::MAG_W'(stg[g-1].dy);
        end
      end else if (g == adc_plc_pkg::ST_ABS) begin : g_abs
        // Divide magnitudes; the sign goes back on after the divider.
        always_comb begin
          stg_next[g] = stg[g-1];
          stg_next[g].neg = stg[g-1].prod[adc_plc_pkg::MAG_W-1] ^
                            stg[g-1].dx[adc_plc_pkg::DIFF_W-1];
          stg_next[g].nq  = stg[g-1].prod[adc_plc_pkg::MAG_W-1] ?
                            adc_plc_pkg::MAG_W'(-stg[g-1].prod) :
                            adc_plc_pkg::MAG_W'(stg[g-1].prod);
          stg_next[g].den = stg[g-1].dx[adc_plc_pkg::DIFF_W-1] ?
                            adc_plc_pkg::MV_W'(-stg[g-1].dx) :
                            adc_plc_pkg::MV_W'(stg[g-1].dx);
          stg_next[g].rem = '0;
        end
      end else if (g < adc_plc_pkg::ST_SIGN) begin : g_div
        // One restoring step: shift in a dividend bit, subtract if it fits.
        logic [adc_plc_pkg::MV_W:0] trial;
        logic                       fits;
        always_comb begin
          trial = {stg[g-1].rem, stg[g-1].nq[adc_plc_pkg::MAG_W-1]};
          fits  = trial >= {1'b0, stg[g-1].den};
          stg_next[g] = stg[g-1];
          stg_next[g].rem = fits ? adc_plc_pkg::MV_W'(trial - {1'b0, stg[g-1].den}) :
                                   trial[adc_plc_pkg::MV_W-1:0];
          stg_next[g].nq  = {stg[g-1].nq[adc_plc_pkg::MAG_W-2:0], fits};
        end
      end else if (g == adc_plc_pkg::ST_SIGN) begin : g_sign
        always_comb begin
          stg_next[g] = stg[g-1];
          stg_next[g].qs = stg[g-1].neg ? -$signed({1'b0, stg[g-1].nq}) :
                                           $signed({1'b0, stg[g-1].nq});
        end
      end else begin : g_out
        // Add the segment base, then pass raw through or saturate.
        logic signed [adc_plc_pkg::SUM_W-1:0] sum;
        always_comb begin
          sum = $signed({{(adc_plc_pkg::SUM_W - adc_plc_pkg::MV_W){1'b0}}, stg[g-1].y0}) +
                adc_plc_pkg::SUM_W'(stg[g-1].qs);
          stg_next[g] = stg[g-1];
          if (stg[g-1].bypass) begin
            stg_next[g].corr = $signed({1'b0, stg[g-1].raw});
            stg_next[g].flag = 1'b1;
          end else if (sum > adc_plc_pkg::SAT_MAX) begin
            stg_next[g].corr = adc_plc_pkg::CORR_W'(adc_plc_pkg::SAT_MAX);
            stg_next[g].flag = 1'b1;
          end else if (sum < adc_plc_pkg::SAT_MIN) begin
            stg_next[g].corr = adc_plc_pkg::CORR_W'(adc_plc_pkg::SAT_MIN);
            stg_next[g].flag = 1'b1;
          end else begin
            stg_next[g].corr = sum[adc_plc_pkg::CORR_W-1:0];
            stg_next[g].flag = 1'b0;
          end
        end
      end
    end
  endgenerate

  // ------------------------------------------------------------------
  // Result channel: driven straight from the last stage register
  // ------------------------------------------------------------------
  assign result_valid         = vld[N-1];
  assign raw_millivolts       = stg[N-1].raw;
  assign corrected_millivolts = stg[N-1].corr;
  assign out_flag             = stg[N-1].flag;

endmodule

`default_nettype wire
